// ===== rtl/u2u_pkg.sv =====
// shared beat types, constants and code-point helpers for the utf-8 to utf-16 decoder
package u2u_pkg;

	// result queue depth; one decoded byte pushes at most two units
	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw    = $clog2(QDepth);
	localparam int unsigned QCw    = $clog2(QDepth + 1);

	localparam logic [15:0] ReplChar  = 16'hFFFD;
	localparam logic [20:0] SuppBase  = 21'h10000;
	localparam logic [15:0] HiSurBase = 16'hD800;
	localparam logic [5:0]  LoSurTag  = 6'b110111;

	// lead byte limits
	localparam logic [7:0] Lead1Max = 8'h7F;
	localparam logic [7:0] Lead2Max = 8'hDF;
	localparam logic [7:0] Lead3Max = 8'hEF;
	localparam logic [7:0] Lead4Max = 8'hF7;
	localparam logic [1:0] ContTag  = 2'b10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        is_replacement;
		logic        last_of_run;
	} out_beat_t;

	// what the decoder hands to the result queue for one byte
	typedef struct packed {
		logic      first;
		logic      second;
		out_beat_t unit0;
		out_beat_t unit1;
	} dec_push_t;

	function automatic out_beat_t mk_unit(logic [15:0] cu, logic repl, logic last);
		out_beat_t u;
		u.code_unit      = cu;
		u.is_replacement = repl;
		u.last_of_run    = last;
		return u;
	endfunction

endpackage

// ===== rtl/utf8_to_utf16_decoder.sv =====
// top level of the utf-8 byte stream to utf-16 code unit decoder
//
//   channel  | valid       | stall       | payload
//   ---------+-------------+-------------+--------------------------------
//   bytes    | byte_valid  | byte_stall  | byte_data (in_beat_t)
//   units    | unit_valid  | unit_stall  | unit_data (out_beat_t)
//
// one byte beat a cycle while byte_stall is low: input register, then decode logic
// into a four-entry queue; a byte's first unit passes the input register and the
// queue before it is offered, and a low surrogate follows its high half
// byte_stall rises only while the queue holds more than two units
// arst_n clears the sequence state, the input register and the queue
module utf8_to_utf16_decoder import u2u_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_beat_t  byte_data,
	output logic      unit_valid,
	input  logic      unit_stall,
	output out_beat_t unit_data
);

	logic           valid_s1;
	in_beat_t       beat_s1;
	logic           room;
	logic           fire;
	logic           take;
	dec_push_t      push;
	logic [QCw-1:0] level;

	assign fire       = valid_s1 & room;
	assign byte_stall = valid_s1 & ~room;
	assign take       = byte_valid & ~byte_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take || fire) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beat_s1 <= byte_data;
		end
	end

	u2u_decode u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.beat   (beat_s1),
		.push   (push)
	);

	u2u_out_queue u_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.valid  (unit_valid),
		.stall  (unit_stall),
		.data   (unit_data),
		.level  (level)
	);

	// queue never overfills
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		level <= QCw'(QDepth))
		else $error("result queue overfilled");

	// units only pushed when two slots are free
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.first |-> level <= QCw'(QDepth - 2))
		else $error("push without room");

	// replacement flag only on the replacement character
	a_repl: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && unit_data.is_replacement |-> unit_data.code_unit == ReplChar)
		else $error("replacement flag on other unit");

	// a unit that is not last is a surrogate
	a_high: assert property (@(posedge clk) disable iff (!arst_n)
		unit_valid && !unit_data.last_of_run |-> unit_data.code_unit[15:11] == 5'b11011)
		else $error("non-final unit is not a surrogate");

endmodule

// ===== rtl/u2u_decode.sv =====
// sequence state and per-byte decode into up to two utf-16 units
module u2u_decode import u2u_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_beat_t  beat,
	output dec_push_t push
);

	logic [1:0]  rem_q;
	logic [20:0] acc_q;
	logic        sv_q;

	logic [1:0]  rem_n;
	logic [20:0] acc_n;
	logic        sv_n;
	logic [20:0] acc_sh;
	logic [20:0] cp_off;
	logic [7:0]  c;

	// code point with this byte's payload shifted in, and its offset above the bmp
	assign c      = beat.data_byte;
	assign acc_sh = {acc_q[14:0], c[5:0]};
	assign cp_off = acc_sh - SuppBase;

	// next state and results for the byte in the input register
	always_comb begin
		rem_n = rem_q;
		acc_n = acc_q;
		sv_n  = sv_q;
		push  = '0;
		if (rem_q == 2'd0) begin
			if (c <= Lead1Max) begin
				push.first = 1'b1;
				push.unit0 = mk_unit({8'h00, c}, 1'b0, 1'b1);
			end else if (c <= Lead2Max) begin
				acc_n = {16'h0, c[4:0]};
				rem_n = 2'd1;
				sv_n  = 1'b1;
			end else if (c <= Lead3Max) begin
				acc_n = {17'h0, c[3:0]};
				rem_n = 2'd2;
				sv_n  = 1'b1;
			end else if (c <= Lead4Max) begin
				acc_n = {18'h0, c[2:0]};
				rem_n = 2'd3;
				sv_n  = 1'b1;
			end else begin
				push.first = 1'b1;
				push.unit0 = mk_unit(ReplChar, 1'b1, 1'b1);
			end
		end else begin
			sv_n  = sv_q & (c[7:6] == ContTag);
			acc_n = acc_sh;
			rem_n = rem_q - 2'd1;
			if (rem_n == 2'd0) begin
				push.first = 1'b1;
				if (!sv_n) begin
					push.unit0 = mk_unit(ReplChar, 1'b1, 1'b1);
				end else if (acc_n[20:16] == 5'd0) begin
					push.unit0 = mk_unit(acc_n[15:0], 1'b0, 1'b1);
				end else begin
					// surrogate pair, high half first
					push.second = 1'b1;
					push.unit0  = mk_unit(HiSurBase + {5'd0, cp_off[20:10]}, 1'b0, 1'b0);
					push.unit1  = mk_unit({LoSurTag, cp_off[9:0]}, 1'b0, 1'b1);
				end
				acc_n = '0;
				sv_n  = 1'b1;
			end
		end
		// end of string cuts any open sequence and clears state
		if (beat.end_of_string) begin
			if (rem_n != 2'd0) begin
				push.first  = 1'b1;
				push.second = 1'b0;
				push.unit0  = mk_unit(ReplChar, 1'b1, 1'b1);
			end
			rem_n = '0;
			acc_n = '0;
			sv_n  = 1'b1;
		end
		if (!fire) begin
			push.first  = 1'b0;
			push.second = 1'b0;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			acc_q <= '0;
			sv_q  <= 1'b1;
		end else if (fire) begin
			rem_q <= rem_n;
			acc_q <= acc_n;
			sv_q  <= sv_n;
		end
	end

endmodule

// ===== rtl/u2u_out_queue.sv =====
// small result queue taking one or two units a cycle and giving one a beat
module u2u_out_queue import u2u_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dec_push_t push,
	output logic      room,
	output logic      valid,
	input  logic      stall,
	output out_beat_t data,
	output logic [QCw-1:0] level
);

	out_beat_t       mem [QDepth];
	logic [QAw-1:0]  wr_q;
	logic [QAw-1:0]  rd_q;
	logic [QCw-1:0]  cnt_q;
	logic            pop;
	logic [QCw-1:0]  n_push;
	logic [QAw-1:0]  wr_p1;

	assign valid  = (cnt_q != '0);
	assign data   = mem[rd_q];
	assign pop    = valid & ~stall;
	assign room   = (cnt_q <= QCw'(QDepth - 2));
	assign level  = cnt_q;
	assign wr_p1  = wr_q + QAw'(1);
	assign n_push = QCw'(push.first) + QCw'(push.second);

	// storage
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem[wr_q] <= push.unit0;
		end
		if (push.second) begin
			mem[wr_p1] <= push.unit1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QAw'(n_push);
			rd_q  <= rd_q + QAw'(pop);
			cnt_q <= cnt_q + n_push - QCw'(pop);
		end
	end

endmodule

// ===== tb/utf8_to_utf16_decoder_test.sv =====
// self-checking testbench for the utf-8 to utf-16 stream decoder
module utf8_to_utf16_decoder_test;
	import u2u_pkg::*;

	localparam int RandomBytes = 900;
	localparam int QuietLimit  = 2000;
	localparam int DrainCycles = 16;
	localparam int IdlePct     = 17;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_beat_t  byte_data = '0;
	logic      unit_valid;
	logic      unit_stall = 1'b0;
	out_beat_t unit_data;

	// decoder shadow state
	logic [1:0]  seq_left = 2'd0;
	logic [20:0] cp_acc = 21'd0;
	logic        seq_ok = 1'b1;
	out_beat_t   unit_q[$];

	bit idle_on = 1'b1;
	int err_count = 0;
	int bytes_sent = 0;
	int strings_sent = 0;
	int units_seen = 0;
	int repl_seen = 0;
	int pairs_seen = 0;
	int quiet = 0;

	utf8_to_utf16_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.unit_valid (unit_valid),
		.unit_stall (unit_stall),
		.unit_data  (unit_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void push_unit(logic [15:0] cu, logic repl, logic last);
		out_beat_t u;
		u.code_unit      = cu;
		u.is_replacement = repl;
		u.last_of_run    = last;
		unit_q.insert(unit_q.size(), u);
	endfunction

	// expected utf-16 units for one accepted byte beat
	function automatic void predict_units(in_beat_t b);
		logic [20:0] cp;
		if (seq_left == 2'd0) begin
			if (b.data_byte <= 8'h7F) begin
				push_unit({8'h00, b.data_byte}, 1'b0, 1'b1);
			end else if (b.data_byte <= 8'hDF) begin
				cp_acc = {16'd0, b.data_byte[4:0]};
				seq_left = 2'd1;
				seq_ok = 1'b1;
			end else if (b.data_byte <= 8'hEF) begin
				cp_acc = {17'd0, b.data_byte[3:0]};
				seq_left = 2'd2;
				seq_ok = 1'b1;
			end else if (b.data_byte <= 8'hF7) begin
				cp_acc = {18'd0, b.data_byte[2:0]};
				seq_left = 2'd3;
				seq_ok = 1'b1;
			end else begin
				push_unit(16'hFFFD, 1'b1, 1'b1);
			end
		end else begin
			// continuation: always consumed, flagged bad if not 10xxxxxx
			if (b.data_byte[7:6] != 2'b10)
				seq_ok = 1'b0;
			cp_acc = {cp_acc[14:0], b.data_byte[5:0]};
			seq_left = seq_left - 2'd1;
			if (seq_left == 2'd0) begin
				if (!seq_ok) begin
					push_unit(16'hFFFD, 1'b1, 1'b1);
				end else if (cp_acc < 21'h10000) begin
					push_unit(cp_acc[15:0], 1'b0, 1'b1);
				end else begin
					cp = cp_acc - 21'h10000;
					push_unit(16'hD800 + {5'd0, cp[20:10]}, 1'b0, 1'b0);
					push_unit(16'hDC00 + {6'd0, cp[9:0]}, 1'b0, 1'b1);
				end
				cp_acc = 21'd0;
				seq_ok = 1'b1;
			end
		end
		// end mark: a pending sequence turns into one replacement
		if (b.end_of_string) begin
			if (seq_left != 2'd0)
				push_unit(16'hFFFD, 1'b1, 1'b1);
			seq_left = 2'd0;
			cp_acc = 21'd0;
			seq_ok = 1'b1;
		end
	endfunction

	// one byte beat, entered and left at a falling edge
	task automatic send_byte(input logic [7:0] d, input logic eos);
		while (idle_on && $urandom_range(0, 99) < IdlePct) begin
			byte_valid = 1'b0;
			@(negedge clk);
		end
		byte_valid = 1'b1;
		byte_data.data_byte = d;
		byte_data.end_of_string = eos;
		do @(posedge clk); while (byte_stall);
		predict_units(byte_data);
		bytes_sent++;
		if (eos)
			strings_sent++;
		@(negedge clk);
	endtask

	// hold the byte side until every expected unit has come out
	task automatic wait_drained();
		byte_valid = 1'b0;
		while (unit_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random sequence of a given length, optionally with a bad continuation or cut short
	task automatic send_seq(input int len, input bit bad, input bit cut);
		logic [7:0] seq_b[4];
		int n;
		int bad_pos;
		logic eos;
		case (len)
			1: seq_b[0] = 8'($urandom_range(0, 127));
			2: seq_b[0] = 8'($urandom_range(128, 223));
			3: seq_b[0] = 8'hE0 | 8'($urandom_range(0, 15));
			default: seq_b[0] = 8'hF0 | 8'($urandom_range(0, 7));
		endcase
		for (int i = 1; i < 4; i++)
			seq_b[i] = 8'h80 | 8'($urandom_range(0, 63));
		if (bad) begin
			bad_pos = $urandom_range(1, len - 1);
			seq_b[bad_pos] = 8'($urandom_range(0, 255));
			if (seq_b[bad_pos][7:6] == 2'b10)
				seq_b[bad_pos][6] = 1'b1;
		end
		n = cut ? $urandom_range(1, len - 1) : len;
		eos = cut || ($urandom_range(0, 9) == 0);
		for (int i = 0; i < n; i++)
			send_byte(seq_b[i], eos && (i == n - 1));
	endtask

	// ascii extremes and invalid lead bytes
	task automatic test_single_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hF8, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	// stray continuation bytes, then three- and four-byte sequences incl. a real u+fffd and a max pair
	task automatic test_multibyte();
		send_byte(8'h80, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBD, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hF7, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b1);
	endtask

	// non-continuation byte inside a sequence still counts toward its length
	task automatic test_bad_continuation();
		send_byte(8'hE2, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'hAC, 1'b0);
	endtask

	// end mark while bytes are still expected, with and without a bad byte
	task automatic test_cut_short();
		send_byte(8'hF0, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(8'hE2, 1'b1);
	endtask

	// mostly well-formed strings, some broken ones and raw noise
	task automatic test_random_strings();
		int start;
		int kind;
		bit paused;
		start = bytes_sent;
		paused = 1'b0;
		while (bytes_sent - start < RandomBytes) begin
			idle_on = !((bytes_sent - start >= 300) && (bytes_sent - start < 450));
			if (!paused && bytes_sent - start >= 600) begin
				wait_drained();
				paused = 1'b1;
			end
			kind = $urandom_range(0, 99);
			if (kind < 70)
				send_seq($urandom_range(1, 4), 1'b0, 1'b0);
			else if (kind < 80)
				send_seq($urandom_range(2, 4), 1'b1, 1'b0);
			else if (kind < 88)
				send_seq($urandom_range(2, 4), 1'b0, 1'b1);
			else
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
		end
		idle_on = 1'b1;
	endtask

	// receiver stalls at random while idling is on
	always @(negedge clk)
		unit_stall = idle_on && ($urandom_range(0, 99) < IdlePct);

	// compare each unit beat against the oldest expected unit
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && unit_valid && !unit_stall) begin
			if (unit_q.size() == 0) begin
				$error("unexpected unit: code_unit %h", unit_data.code_unit);
				err_count++;
			end else begin
				want = unit_q.pop_front();
				units_seen++;
				if (want.is_replacement)
					repl_seen++;
				if (!want.last_of_run)
					pairs_seen++;
				if (unit_data.code_unit !== want.code_unit) begin
					$error("code_unit: expected %h, got %h", want.code_unit,
						unit_data.code_unit);
					err_count++;
				end
				if (unit_data.is_replacement !== want.is_replacement) begin
					$error("is_replacement: expected %b, got %b", want.is_replacement,
						unit_data.is_replacement);
					err_count++;
				end
				if (unit_data.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %b, got %b", want.last_of_run,
						unit_data.last_of_run);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (unit_valid && !unit_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QuietLimit) begin
			$display("timeout after %0d idle cycles", quiet);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_single_bytes();
		test_multibyte();
		test_bad_continuation();
		test_cut_short();
		test_random_strings();
		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (unit_q.size() != 0) begin
			$error("%0d expected units never arrived", unit_q.size());
			err_count++;
		end
		$display("sent %0d bytes in %0d strings; checked %0d units", bytes_sent,
			strings_sent, units_seen);
		$display("of which %0d replacements and %0d surrogate pairs, %0d mismatches",
			repl_seen, pairs_seen, err_count);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
